/* src/fsp_pkg.sv */
package fsp_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned NumberBitsDef = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 21;

  typedef logic [CpW-1:0] cp_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_HOLD,
    PH_SIGN,
    PH_Z,
    PH_HASH,
    PH_ZERO,
    PH_WIDTH,
    PH_USCORE,
    PH_COMMA2,
    PH_DOT,
    PH_PREC,
    PH_TYPE,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_NO_PREC,
    ST_INVALID,
    ST_CONFLICT,
    ST_SEP_TYPE
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_ALIGN = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_TYPE  = CfgIdxW'(1);

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
  localparam logic [1:0] ALIGN_SIGN   = 2'd2;
  localparam logic [1:0] ALIGN_CENTER = 2'd3;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;
  localparam logic [1:0] SIGN_SPACE = 2'd3;

  localparam logic [1:0] GRP_NONE   = 2'd0;
  localparam logic [1:0] GRP_COMMA  = 2'd1;
  localparam logic [1:0] GRP_USCORE = 2'd2;
  localparam logic [1:0] GRP_FOUR   = 2'd3;

  localparam cp_t CH_NUL    = 21'h00000;
  localparam cp_t CH_SPACE  = 21'h00020;
  localparam cp_t CH_HASH   = 21'h00023;
  localparam cp_t CH_PCT    = 21'h00025;
  localparam cp_t CH_PLUS   = 21'h0002B;
  localparam cp_t CH_COMMA  = 21'h0002C;
  localparam cp_t CH_MINUS  = 21'h0002D;
  localparam cp_t CH_DOT    = 21'h0002E;
  localparam cp_t CH_ZERO   = 21'h00030;
  localparam cp_t CH_NINE   = 21'h00039;
  localparam cp_t CH_LT     = 21'h0003C;
  localparam cp_t CH_EQ     = 21'h0003D;
  localparam cp_t CH_GT     = 21'h0003E;
  localparam cp_t CH_XU     = 21'h00058;
  localparam cp_t CH_CARET  = 21'h0005E;
  localparam cp_t CH_USCORE = 21'h0005F;
  localparam cp_t CH_B      = 21'h00062;
  localparam cp_t CH_O      = 21'h0006F;
  localparam cp_t CH_X      = 21'h00078;
  localparam cp_t CH_Z      = 21'h0007A;
  localparam cp_t CH_AIN    = 21'h00639;
  localparam cp_t CH_FEH    = 21'h00641;
  localparam cp_t CH_HEH    = 21'h00647;

  localparam logic [1:0] DefaultAlignRst = ALIGN_RIGHT;
  localparam cp_t        DefaultTypeRst  = CH_NUL;

  typedef struct packed {
    phase_e     phase;
    cp_t        held;
    logic       fill_seen;
    logic       align_seen;
    cp_t        fill;
    logic [1:0] align;
    logic [1:0] sign;
    logic       nz;
    logic       alt;
    logic [1:0] group;
    logic       digit_seen;
    logic       width_vld;
    logic       prec_vld;
    status_e    err;
  } ctrl_t;

  typedef struct packed {
    status_e            status;
    cp_t                fill_char;
    logic [1:0]         align_mode;
    logic [1:0]         sign_mode;
    logic               no_negative_zero;
    logic               alternate_form;
    logic signed [31:0] field_width;
    logic [1:0]         grouping_mode;
    logic signed [31:0] precision_value;
    cp_t                type_char;
  } res_t;

  // Returns {hit, code} for the four alignment characters.
  function automatic logic [2:0] align_lookup(cp_t c);
    logic [2:0] r;
    unique case (c)
      CH_LT:    r = {1'b1, ALIGN_LEFT};
      CH_GT:    r = {1'b1, ALIGN_RIGHT};
      CH_EQ:    r = {1'b1, ALIGN_SIGN};
      CH_CARET: r = {1'b1, ALIGN_CENTER};
      default:  r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic ctrl_t start_ctrl(logic [1:0] dalign);
    ctrl_t s;
    s            = '0;
    s.phase      = PH_START;
    s.fill       = CH_SPACE;
    s.align      = dalign;
    s.err        = ST_OK;
    return s;
  endfunction

endpackage

/* src/fsp_if.sv */
interface fsp_in_if import fsp_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  code_point;
  logic last_char;

  modport source (output valid, output code_point, output last_char, input ready);
  modport sink (input valid, input code_point, input last_char, output ready);
endinterface

interface fsp_cfg_if import fsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface fsp_out_if import fsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  cp_t                fill_char;
  logic [1:0]         align_mode;
  logic [1:0]         sign_mode;
  logic               no_negative_zero;
  logic               alternate_form;
  logic signed [31:0] field_width;
  logic [1:0]         grouping_mode;
  logic signed [31:0] precision_value;
  cp_t                type_char;

  modport source (
    output valid, output status, output fill_char, output align_mode, output sign_mode,
    output no_negative_zero, output alternate_form, output field_width, output grouping_mode,
    output precision_value, output type_char, input ready
  );
  modport sink (
    input valid, input status, input fill_char, input align_mode, input sign_mode,
    input no_negative_zero, input alternate_form, input field_width, input grouping_mode,
    input precision_value, input type_char, output ready
  );
endinterface

/* src/fsp_feed.sv */
module fsp_feed import fsp_pkg::*; #(
  parameter int unsigned NUMBER_BITS = NumberBitsDef
) (
  input  ctrl_t                  ctrl_i,
  input  logic [NUMBER_BITS-1:0] acc_i,
  input  logic [NUMBER_BITS-1:0] width_i,
  input  logic [NUMBER_BITS-1:0] prec_i,
  input  cp_t                    cp_i,
  input  logic                   last_i,
  input  logic [1:0]             dalign_i,
  output ctrl_t                  ctrl_o,
  output logic [NUMBER_BITS-1:0] acc_o,
  output logic [NUMBER_BITS-1:0] width_o,
  output logic [NUMBER_BITS-1:0] prec_o
);

  logic                   is_digit;
  logic [NUMBER_BITS+3:0] prod;
  logic                   ovf;
  logic [2:0]             al;
  phase_e                 p;
  logic                   go;

  assign is_digit = (cp_i >= CH_ZERO) && (cp_i <= CH_NINE);
  assign al       = align_lookup(cp_i);

  // acc * 10 + digit; anything above the low NUMBER_BITS bits is an overflow.
  assign prod = ({4'b0000, acc_i} << 3) + ({4'b0000, acc_i} << 1)
              + (NUMBER_BITS + 4)'(cp_i[3:0]);
  assign ovf  = |prod[NUMBER_BITS+3:NUMBER_BITS];

  // Each part of the specifier is tried in order; go drops once one consumes the character.
  always_comb begin
    ctrl_o  = ctrl_i;
    acc_o   = acc_i;
    width_o = width_i;
    prec_o  = prec_i;
    p       = ctrl_i.phase;
    go      = 1'b1;

    if (p == PH_START || p == PH_HOLD) begin
      if (al[2]) begin
        ctrl_o.align      = al[1:0];
        ctrl_o.align_seen = 1'b1;
        ctrl_o.phase      = PH_SIGN;
        go                = 1'b0;
      end else begin
        p = PH_SIGN;
      end
    end

    if (go && p == PH_SIGN) begin
      if (cp_i == CH_PLUS || cp_i == CH_MINUS || cp_i == CH_SPACE) begin
        if (cp_i == CH_PLUS) begin
          ctrl_o.sign = SIGN_PLUS;
        end else if (cp_i == CH_MINUS) begin
          ctrl_o.sign = SIGN_MINUS;
        end else begin
          ctrl_o.sign = SIGN_SPACE;
        end
        ctrl_o.phase = PH_Z;
        go           = 1'b0;
      end else begin
        p = PH_Z;
      end
    end

    if (go && p == PH_Z) begin
      if (cp_i == CH_Z) begin
        ctrl_o.nz    = 1'b1;
        ctrl_o.phase = PH_HASH;
        go           = 1'b0;
      end else begin
        p = PH_HASH;
      end
    end

    if (go && p == PH_HASH) begin
      if (cp_i == CH_HASH) begin
        ctrl_o.alt   = 1'b1;
        ctrl_o.phase = PH_ZERO;
        go           = 1'b0;
      end else begin
        p = PH_ZERO;
      end
    end

    if (go && p == PH_ZERO) begin
      if (!ctrl_i.fill_seen && cp_i == CH_ZERO) begin
        ctrl_o.fill = CH_ZERO;
        if (!ctrl_i.align_seen && dalign_i == ALIGN_RIGHT) begin
          ctrl_o.align = ALIGN_SIGN;
        end
        ctrl_o.phase = PH_WIDTH;
        go           = 1'b0;
      end else begin
        p = PH_WIDTH;
      end
    end

    if (go && p == PH_WIDTH) begin
      if (is_digit) begin
        go = 1'b0;
        if (ovf) begin
          ctrl_o.err   = ST_OVERFLOW;
          ctrl_o.phase = PH_ERROR;
        end else begin
          acc_o             = prod[NUMBER_BITS-1:0];
          ctrl_o.digit_seen = 1'b1;
          ctrl_o.phase      = PH_WIDTH;
        end
      end else begin
        width_o           = acc_i;
        ctrl_o.width_vld  = ctrl_i.digit_seen;
        acc_o             = '0;
        ctrl_o.digit_seen = 1'b0;
        if (cp_i == CH_COMMA) begin
          ctrl_o.group = GRP_COMMA;
          ctrl_o.phase = PH_USCORE;
          go           = 1'b0;
        end else begin
          p = PH_USCORE;
        end
      end
    end

    if (go && p == PH_USCORE) begin
      if (cp_i == CH_USCORE) begin
        go = 1'b0;
        if (ctrl_o.group != GRP_NONE) begin
          ctrl_o.err   = ST_CONFLICT;
          ctrl_o.phase = PH_ERROR;
        end else begin
          ctrl_o.group = GRP_USCORE;
          ctrl_o.phase = PH_COMMA2;
        end
      end else begin
        p = PH_COMMA2;
      end
    end

    if (go && p == PH_COMMA2) begin
      if (cp_i == CH_COMMA && ctrl_o.group == GRP_USCORE) begin
        ctrl_o.err   = ST_CONFLICT;
        ctrl_o.phase = PH_ERROR;
        go           = 1'b0;
      end else begin
        p = PH_DOT;
      end
    end

    if (go && p == PH_DOT) begin
      if (cp_i == CH_DOT) begin
        acc_o             = '0;
        ctrl_o.digit_seen = 1'b0;
        ctrl_o.phase      = PH_PREC;
        go                = 1'b0;
      end else begin
        p = PH_TYPE;
      end
    end

    if (go && p == PH_PREC) begin
      if (is_digit) begin
        go = 1'b0;
        if (ovf) begin
          ctrl_o.err   = ST_OVERFLOW;
          ctrl_o.phase = PH_ERROR;
        end else begin
          acc_o             = prod[NUMBER_BITS-1:0];
          ctrl_o.digit_seen = 1'b1;
          ctrl_o.phase      = PH_PREC;
        end
      end else if (!ctrl_i.digit_seen) begin
        ctrl_o.err   = ST_NO_PREC;
        ctrl_o.phase = PH_ERROR;
        go           = 1'b0;
      end else begin
        prec_o            = acc_i;
        ctrl_o.prec_vld   = 1'b1;
        acc_o             = '0;
        ctrl_o.digit_seen = 1'b0;
        p                 = PH_TYPE;
      end
    end

    if (go) begin
      if (p == PH_TYPE && last_i) begin
        ctrl_o.held  = cp_i;
        ctrl_o.phase = PH_DONE;
      end else begin
        ctrl_o.err   = ST_INVALID;
        ctrl_o.phase = PH_ERROR;
      end
    end
  end

endmodule

/* src/fsp_finish.sv */
module fsp_finish import fsp_pkg::*; #(
  parameter int unsigned NUMBER_BITS = NumberBitsDef
) (
  input  ctrl_t                  ctrl_i,
  input  logic [NUMBER_BITS-1:0] acc_i,
  input  logic [NUMBER_BITS-1:0] width_i,
  input  logic [NUMBER_BITS-1:0] prec_i,
  input  cp_t                    dtype_i,
  output res_t                   res_o
);

  ctrl_t                   s;
  logic [NUMBER_BITS-1:0]  wv;
  logic [NUMBER_BITS-1:0]  pv;
  cp_t                     typ;
  logic                    type_ok;
  logic                    type_bin;
  logic [NUMBER_BITS+31:0] wext;
  logic [NUMBER_BITS+31:0] pext;

  always_comb begin
    s  = ctrl_i;
    wv = width_i;
    pv = prec_i;

    // A number still open at the last character is closed here.
    if (s.phase == PH_WIDTH) begin
      wv          = acc_i;
      s.width_vld = s.digit_seen;
    end else if (s.phase == PH_PREC) begin
      if (!s.digit_seen) begin
        s.err   = ST_NO_PREC;
        s.phase = PH_ERROR;
      end else begin
        pv         = acc_i;
        s.prec_vld = 1'b1;
      end
    end

    typ      = (s.phase == PH_DONE) ? s.held : dtype_i;
    type_ok  = (typ == CH_FEH) || (typ == CH_HEH) || (typ == CH_AIN) ||
               (typ == CH_PCT) || (typ == CH_NUL);
    type_bin = (typ == CH_B) || (typ == CH_O) || (typ == CH_X) || (typ == CH_XU);

    if (s.phase != PH_ERROR && s.group != GRP_NONE && !type_ok) begin
      if (type_bin && s.group == GRP_USCORE) begin
        s.group = GRP_FOUR;
      end else begin
        s.err   = ST_SEP_TYPE;
        s.phase = PH_ERROR;
      end
    end

    wext = {32'd0, wv};
    pext = {32'd0, pv};

    res_o        = '0;
    res_o.status = s.err;
    if (s.phase != PH_ERROR) begin
      res_o.fill_char        = s.fill;
      res_o.align_mode       = s.align;
      res_o.sign_mode        = s.sign;
      res_o.no_negative_zero = s.nz;
      res_o.alternate_form   = s.alt;
      res_o.field_width      = s.width_vld ? wext[31:0] : '1;
      res_o.grouping_mode    = s.group;
      res_o.precision_value  = s.prec_vld ? pext[31:0] : '1;
      res_o.type_char        = typ;
    end
  end

endmodule

/* src/format_spec_parser.sv */
// Channel  | Dir | Payload                                   | Transfer when
// ---------+-----+-------------------------------------------+-----------------------
// in_i     | in  | code_point, last_char                     | valid && ready
// cfg_i    | in  | index (0 default_align, 1 default_type)   | valid && ready
// res_o    | out | status and the nine specifier fields      | valid && ready
//
// One character is taken every cycle while in_i.ready is high; the result of a
// specifier is registered into the output buffer on the transfer of its last
// character; the parse logic between the state registers and that buffer is combinational.
// Reset is asynchronous and active low; there is no clearing pass.
// Results go through a two-entry output buffer, so in_i.ready drops only when both
// entries are full. The configuration channel is always ready.
module format_spec_parser import fsp_pkg::*; #(
  parameter int unsigned NUMBER_BITS = NumberBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsp_in_if.sink    in_i,
  fsp_cfg_if.sink   cfg_i,
  fsp_out_if.source res_o
);

  ctrl_t                  ctrl_q;
  logic [NUMBER_BITS-1:0] acc_q;
  logic [NUMBER_BITS-1:0] wid_q;
  logic [NUMBER_BITS-1:0] prc_q;
  logic [1:0]             dalign_q;
  cp_t                    dtype_q;
  res_t                   out_q;
  logic                   out_vld_q;
  res_t                   skid_q;
  logic                   skid_vld_q;

  ctrl_t                  m_ctrl, h1_ctrl, h2_ctrl, st_ctrl;
  logic [NUMBER_BITS-1:0] m_acc, h1_acc, h2_acc, st_acc;
  logic [NUMBER_BITS-1:0] m_wid, h1_wid, h2_wid, st_wid;
  logic [NUMBER_BITS-1:0] m_prc, h1_prc, h2_prc, st_prc;
  logic [NUMBER_BITS-1:0] h1_acc_small;
  cp_t                    cp;
  logic                   last;
  logic                   take;
  logic                   push;
  logic                   out_free;
  logic                   cfg_wr;
  logic [2:0]             cp_al;
  res_t                   fin_res;

  assign cp     = in_i.code_point;
  assign last   = in_i.last_char;
  assign take   = in_i.valid && in_i.ready;
  assign push   = take && last;
  assign cfg_wr = cfg_i.valid && cfg_i.ready;
  assign cp_al  = align_lookup(cp);

  assign in_i.ready  = !skid_vld_q;
  assign cfg_i.ready = 1'b1;

  fsp_feed #(.NUMBER_BITS(NUMBER_BITS)) u_feed_main (
    .ctrl_i  (ctrl_q),
    .acc_i   (acc_q),
    .width_i (wid_q),
    .prec_i  (prc_q),
    .cp_i    (cp),
    .last_i  (last),
    .dalign_i(dalign_q),
    .ctrl_o  (m_ctrl),
    .acc_o   (m_acc),
    .width_o (m_wid),
    .prec_o  (m_prc)
  );

  // The held first character is parsed with an empty accumulator.
  fsp_feed #(.NUMBER_BITS(NUMBER_BITS)) u_feed_held (
    .ctrl_i  (ctrl_q),
    .acc_i   ('0),
    .width_i (wid_q),
    .prec_i  (prc_q),
    .cp_i    (ctrl_q.held),
    .last_i  (1'b0),
    .dalign_i(dalign_q),
    .ctrl_o  (h1_ctrl),
    .acc_o   (h1_acc),
    .width_o (h1_wid),
    .prec_o  (h1_prc)
  );

  // After one character the accumulator holds at most a single digit.
  assign h1_acc_small = NUMBER_BITS'(h1_acc[3:0]);

  fsp_feed #(.NUMBER_BITS(NUMBER_BITS)) u_feed_next (
    .ctrl_i  (h1_ctrl),
    .acc_i   (h1_acc_small),
    .width_i (h1_wid),
    .prec_i  (h1_prc),
    .cp_i    (cp),
    .last_i  (last),
    .dalign_i(dalign_q),
    .ctrl_o  (h2_ctrl),
    .acc_o   (h2_acc),
    .width_o (h2_wid),
    .prec_o  (h2_prc)
  );

  always_comb begin
    st_ctrl = ctrl_q;
    st_acc  = acc_q;
    st_wid  = wid_q;
    st_prc  = prc_q;
    unique case (ctrl_q.phase)
      PH_START: begin
        if (last) begin
          st_ctrl = m_ctrl;
          st_acc  = m_acc;
          st_wid  = m_wid;
          st_prc  = m_prc;
        end else begin
          st_ctrl.held  = cp;
          st_ctrl.phase = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (cp_al[2]) begin
          // The held character is the fill and this one is the alignment.
          st_ctrl.fill       = ctrl_q.held;
          st_ctrl.align      = cp_al[1:0];
          st_ctrl.fill_seen  = 1'b1;
          st_ctrl.align_seen = 1'b1;
          st_ctrl.phase      = PH_SIGN;
        end else if (h1_ctrl.phase == PH_ERROR) begin
          st_ctrl = h1_ctrl;
          st_acc  = h1_acc;
          st_wid  = h1_wid;
          st_prc  = h1_prc;
        end else begin
          st_ctrl = h2_ctrl;
          st_acc  = h2_acc;
          st_wid  = h2_wid;
          st_prc  = h2_prc;
        end
      end
      PH_ERROR: begin
        st_ctrl = ctrl_q;
      end
      default: begin
        st_ctrl = m_ctrl;
        st_acc  = m_acc;
        st_wid  = m_wid;
        st_prc  = m_prc;
      end
    endcase
  end

  fsp_finish #(.NUMBER_BITS(NUMBER_BITS)) u_finish (
    .ctrl_i (st_ctrl),
    .acc_i  (st_acc),
    .width_i(st_wid),
    .prec_i (st_prc),
    .dtype_i(dtype_q),
    .res_o  (fin_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dalign_q <= DefaultAlignRst;
      dtype_q  <= DefaultTypeRst;
    end else if (cfg_wr) begin
      if (cfg_i.index == CFG_DEFAULT_ALIGN) begin
        dalign_q <= cfg_i.data[1:0];
      end else if (cfg_i.index == CFG_DEFAULT_TYPE) begin
        dtype_q <= cfg_i.data[CpW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= start_ctrl(DefaultAlignRst);
      acc_q  <= '0;
      wid_q  <= '0;
      prc_q  <= '0;
    end else if (take) begin
      if (last) begin
        ctrl_q <= start_ctrl(dalign_q);
        acc_q  <= '0;
      end else begin
        ctrl_q <= st_ctrl;
        acc_q  <= st_acc;
        wid_q  <= st_wid;
        prc_q  <= st_prc;
      end
    end else if (cfg_wr && cfg_i.index == CFG_DEFAULT_ALIGN && ctrl_q.phase == PH_START) begin
      // A specifier that has not started yet picks up the new default.
      ctrl_q.align <= cfg_i.data[1:0];
    end
  end

  assign out_free = !out_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= push;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= fin_res;
        end
      end else if (push) begin
        out_q <= fin_res;
      end
    end else if (push) begin
      skid_q <= fin_res;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.status           = out_q.status;
  assign res_o.fill_char        = out_q.fill_char;
  assign res_o.align_mode       = out_q.align_mode;
  assign res_o.sign_mode        = out_q.sign_mode;
  assign res_o.no_negative_zero = out_q.no_negative_zero;
  assign res_o.alternate_form   = out_q.alternate_form;
  assign res_o.field_width      = out_q.field_width;
  assign res_o.grouping_mode    = out_q.grouping_mode;
  assign res_o.precision_value  = out_q.precision_value;
  assign res_o.type_char        = out_q.type_char;

endmodule

/* dv/format_spec_parser_test.sv */
`timescale 1ns / 100ps

module format_spec_parser_test;
  import fsp_pkg::*;

  localparam cp_t CP_MAX       = 21'h10FFFF;
  localparam int  STUCK_LIMIT  = 1000;
  localparam int  DRAIN_CYCLES = 4;
  localparam int  RANDOM_CHARS = 1950;
  localparam int  ROUNDS       = 6;

  typedef struct {
    string text;   // '@' stands for subst
    cp_t   subst;
    bit    known;
    res_t  want;
  } spec_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  fsp_in_if  in_if ();
  fsp_cfg_if cfg_if ();
  fsp_out_if res_if ();

  format_spec_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // Characters that steer the parser; the last ten serve as type characters.
  cp_t notable [0:22] = '{CH_LT, CH_GT, CH_EQ, CH_CARET, CH_PLUS, CH_MINUS, CH_SPACE, CH_Z,
                          CH_HASH, CH_ZERO, CH_COMMA, CH_USCORE, CH_DOT, CH_PCT, CH_B,
                          CH_O, CH_X, CH_XU, CH_FEH, CH_HEH, CH_AIN, CH_NUL, CP_MAX};

  logic [1:0] round_align [0:ROUNDS-1] = '{ALIGN_LEFT, ALIGN_CENTER, ALIGN_SIGN, ALIGN_RIGHT,
                                           ALIGN_LEFT, ALIGN_RIGHT};
  cp_t        round_type  [0:ROUNDS-1] = '{CP_MAX, CH_X, CH_B, CH_FEH, CH_XU, CH_NUL};

  res_t      expected_specs [$];
  spec_row_t directed_rows [$];
  cp_t       spec_chars [$];

  int mismatches  = 0;
  int stuck_cycles = 0;
  int chars_sent  = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;

  // Parser state as the predictor sees it.
  logic [1:0]      reg_align;
  cp_t             reg_type;
  phase_e          sp_phase;
  cp_t             sp_held;
  bit              sp_fill_seen;
  bit              sp_align_seen;
  cp_t             sp_fill;
  logic [1:0]      sp_align;
  logic [1:0]      sp_sign;
  bit              sp_nz;
  bit              sp_alt;
  logic [1:0]      sp_group;
  logic [31:0]     sp_width;
  logic [31:0]     sp_prec;
  longint unsigned sp_num;
  bit              sp_digits;
  status_e         sp_err;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_spec();
    sp_phase      = PH_START;
    sp_held       = CH_NUL;
    sp_fill_seen  = 1'b0;
    sp_align_seen = 1'b0;
    sp_fill       = CH_SPACE;
    sp_align      = reg_align;
    sp_sign       = SIGN_NONE;
    sp_nz         = 1'b0;
    sp_alt        = 1'b0;
    sp_group      = GRP_NONE;
    sp_width      = '1;
    sp_prec       = '1;
    sp_num        = 0;
    sp_digits     = 1'b0;
    sp_err        = ST_OK;
  endfunction

  function automatic void align_of(cp_t c, output bit hit, output logic [1:0] code);
    hit = 1'b1;
    case (c)
      CH_LT:    code = ALIGN_LEFT;
      CH_GT:    code = ALIGN_RIGHT;
      CH_EQ:    code = ALIGN_SIGN;
      CH_CARET: code = ALIGN_CENTER;
      default: begin
        hit  = 1'b0;
        code = ALIGN_LEFT;
      end
    endcase
  endfunction

  function automatic void spec_fail(status_e code);
    sp_err   = code;
    sp_phase = PH_ERROR;
  endfunction

  function automatic bit push_digit(cp_t c);
    longint unsigned limit = (64'd1 << NumberBitsDef) - 64'd1;
    longint unsigned d     = c - CH_ZERO;
    if (sp_num > (limit - d) / 10) begin
      spec_fail(ST_OVERFLOW);
      return 1'b0;
    end
    sp_num    = sp_num * 10 + d;
    sp_digits = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pop_number();
    logic [31:0] v;
    v         = sp_digits ? sp_num[31:0] : '1;
    sp_num    = 0;
    sp_digits = 1'b0;
    return v;
  endfunction

  // Walks the parts in order, starting at the phase the parser is in; a character
  // that a part does not take falls through to the next part.
  function automatic void parse_char(cp_t c, bit last, bit at_start);
    phase_e     p   = at_start ? PH_SIGN : sp_phase;
    bit         dig = (c >= CH_ZERO) && (c <= CH_NINE);
    bit         hit;
    logic [1:0] code;
    if (at_start) begin
      align_of(c, hit, code);
      if (hit) begin
        sp_align      = code;
        sp_align_seen = 1'b1;
        sp_phase      = PH_SIGN;
        return;
      end
    end
    if (p == PH_SIGN) begin
      if (c == CH_PLUS || c == CH_MINUS || c == CH_SPACE) begin
        sp_sign  = (c == CH_PLUS) ? SIGN_PLUS : ((c == CH_MINUS) ? SIGN_MINUS : SIGN_SPACE);
        sp_phase = PH_Z;
        return;
      end
      p = PH_Z;
    end
    if (p == PH_Z) begin
      if (c == CH_Z) begin
        sp_nz    = 1'b1;
        sp_phase = PH_HASH;
        return;
      end
      p = PH_HASH;
    end
    if (p == PH_HASH) begin
      if (c == CH_HASH) begin
        sp_alt   = 1'b1;
        sp_phase = PH_ZERO;
        return;
      end
      p = PH_ZERO;
    end
    if (p == PH_ZERO) begin
      if (!sp_fill_seen && c == CH_ZERO) begin
        sp_fill = CH_ZERO;
        if (!sp_align_seen && reg_align == ALIGN_RIGHT) sp_align = ALIGN_SIGN;
        sp_phase = PH_WIDTH;
        return;
      end
      p = PH_WIDTH;
    end
    if (p == PH_WIDTH) begin
      if (dig) begin
        if (push_digit(c)) sp_phase = PH_WIDTH;
        return;
      end
      sp_width = pop_number();
      if (c == CH_COMMA) begin
        sp_group = GRP_COMMA;
        sp_phase = PH_USCORE;
        return;
      end
      p = PH_USCORE;
    end
    if (p == PH_USCORE) begin
      if (c == CH_USCORE) begin
        if (sp_group != GRP_NONE) begin
          spec_fail(ST_CONFLICT);
          return;
        end
        sp_group = GRP_USCORE;
        sp_phase = PH_COMMA2;
        return;
      end
      p = PH_COMMA2;
    end
    if (p == PH_COMMA2) begin
      if (c == CH_COMMA && sp_group == GRP_USCORE) begin
        spec_fail(ST_CONFLICT);
        return;
      end
      p = PH_DOT;
    end
    if (p == PH_DOT) begin
      if (c == CH_DOT) begin
        sp_num    = 0;
        sp_digits = 1'b0;
        sp_phase  = PH_PREC;
        return;
      end
      p = PH_TYPE;
    end
    if (p == PH_PREC) begin
      if (dig) begin
        if (push_digit(c)) sp_phase = PH_PREC;
        return;
      end
      if (!sp_digits) begin
        spec_fail(ST_NO_PREC);
        return;
      end
      sp_prec = pop_number();
      p = PH_TYPE;
    end
    if (p == PH_TYPE && last) begin
      sp_held  = c;
      sp_phase = PH_DONE;
      return;
    end
    spec_fail(ST_INVALID);
  endfunction

  // Advances the predictor by one transferred character and, on the last one,
  // queues the expected result.
  function automatic void predict_char(cp_t c, bit last);
    bit         hit;
    logic [1:0] code;
    cp_t        ty;
    res_t       r;
    case (sp_phase)
      PH_START: begin
        if (last) begin
          parse_char(c, 1'b1, 1'b1);
        end else begin
          sp_held  = c;
          sp_phase = PH_HOLD;
        end
      end
      PH_HOLD: begin
        align_of(c, hit, code);
        if (hit) begin
          sp_fill       = sp_held;
          sp_align      = code;
          sp_fill_seen  = 1'b1;
          sp_align_seen = 1'b1;
          sp_phase      = PH_SIGN;
        end else begin
          parse_char(sp_held, 1'b0, 1'b1);
          if (sp_phase != PH_ERROR) parse_char(c, last, 1'b0);
        end
      end
      PH_ERROR: ;
      default: parse_char(c, last, 1'b0);
    endcase
    if (!last) return;
    if (sp_phase == PH_WIDTH) begin
      sp_width = pop_number();
    end else if (sp_phase == PH_PREC) begin
      if (!sp_digits) spec_fail(ST_NO_PREC);
      else sp_prec = pop_number();
    end
    ty = (sp_phase == PH_DONE) ? sp_held : reg_type;
    if (sp_phase != PH_ERROR && sp_group != GRP_NONE &&
        !(ty inside {CH_FEH, CH_HEH, CH_AIN, CH_PCT, CH_NUL})) begin
      if ((ty inside {CH_B, CH_O, CH_X, CH_XU}) && sp_group == GRP_USCORE) begin
        sp_group = GRP_FOUR;
      end else begin
        spec_fail(ST_SEP_TYPE);
      end
    end
    r        = '0;
    r.status = sp_err;
    if (sp_phase != PH_ERROR) begin
      r.fill_char        = sp_fill;
      r.align_mode       = sp_align;
      r.sign_mode        = sp_sign;
      r.no_negative_zero = sp_nz;
      r.alternate_form   = sp_alt;
      r.field_width      = sp_width;
      r.grouping_mode    = sp_group;
      r.precision_value  = sp_prec;
      r.type_char        = ty;
    end
    expected_specs.push_back(r);
    clear_spec();
  endfunction

  function automatic res_t only_status(status_e s);
    res_t r;
    r        = '0;
    r.status = s;
    return r;
  endfunction

  // A clean result under the reset configuration.
  function automatic res_t plain_result(logic [31:0] width, logic [1:0] grp, cp_t ty);
    res_t r;
    r                 = '0;
    r.status          = ST_OK;
    r.fill_char       = CH_SPACE;
    r.align_mode      = ALIGN_RIGHT;
    r.sign_mode       = SIGN_NONE;
    r.field_width     = width;
    r.grouping_mode   = grp;
    r.precision_value = '1;
    r.type_char       = ty;
    return r;
  endfunction

  function automatic void add_row(string text, cp_t subst = CH_NUL, bit known = 1'b0,
                                  res_t want = '0);
    spec_row_t row;
    row.text  = text;
    row.subst = subst;
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic cp_t any_char();
    case ($urandom_range(0, 3))
      0, 1:    return cp_t'($urandom_range(32'h20, 32'h7E));
      2:       return cp_t'($urandom_range(0, CP_MAX));
      default: return notable[$urandom_range(0, 22)];
    endcase
  endfunction

  function automatic void push_number();
    string s;
    int    n;
    n = 0;
    case ($urandom_range(0, 15))
      0:       s = "2147483647";
      1:       s = "2147483648";
      2:       n = $urandom_range(9, 12);
      default: n = $urandom_range(1, 3);
    endcase
    for (int k = 0; k < s.len(); k++) spec_chars.push_back(cp_t'(s[k]));
    repeat (n) spec_chars.push_back(CH_ZERO + cp_t'($urandom_range(0, 9)));
  endfunction

  // Mostly well-formed specifiers with random parts; some pure noise, some damaged.
  function automatic void compose_spec();
    int pos;
    spec_chars.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) spec_chars.push_back(any_char());
      return;
    end
    case ($urandom_range(0, 3))
      0: spec_chars.push_back(notable[$urandom_range(0, 3)]);
      1: begin
        spec_chars.push_back(any_char());
        spec_chars.push_back(notable[$urandom_range(0, 3)]);
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) spec_chars.push_back(notable[$urandom_range(4, 6)]);
    if ($urandom_range(0, 3) == 0) spec_chars.push_back(CH_Z);
    if ($urandom_range(0, 3) == 0) spec_chars.push_back(CH_HASH);
    if ($urandom_range(0, 3) == 0) spec_chars.push_back(CH_ZERO);
    if ($urandom_range(0, 1) == 0) push_number();
    case ($urandom_range(0, 7))
      0, 1: spec_chars.push_back(CH_COMMA);
      2, 3: spec_chars.push_back(CH_USCORE);
      4: begin
        spec_chars.push_back(CH_USCORE);
        spec_chars.push_back(CH_COMMA);
      end
      5: begin
        spec_chars.push_back(CH_COMMA);
        spec_chars.push_back(CH_USCORE);
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      spec_chars.push_back(CH_DOT);
      if ($urandom_range(0, 7) != 0) push_number();
    end
    if ($urandom_range(0, 3) != 0) begin
      spec_chars.push_back(($urandom_range(0, 2) != 0) ? notable[$urandom_range(13, 22)]
                                                       : any_char());
    end
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, spec_chars.size());
      if (pos < spec_chars.size() && $urandom_range(0, 1) == 1) spec_chars[pos] = any_char();
      else spec_chars.insert(pos, any_char());
    end
    if (spec_chars.size() == 0) spec_chars.push_back(any_char());
  endfunction

  task automatic send_char(cp_t c, bit last);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.code_point <= c;
    in_if.last_char  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_char(c, last);
    chars_sent++;
  endtask

  task automatic send_spec(input cp_t chars [$]);
    for (int k = 0; k < chars.size(); k++) send_char(chars[k], k == chars.size() - 1);
  endtask

  // Holds the sender off until every expected result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_specs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_DEFAULT_ALIGN) reg_align = val[1:0];
    else if (idx == CFG_DEFAULT_TYPE) reg_type = val;
    clear_spec();
    @(posedge clk_i);
  endtask

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10) $display("mismatch in %s: expected %h, got %h", what, want, got);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  initial begin : result_stalls
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_specs.size() == 0) begin
          flag_mismatch("status of unexpected result", '0, res_if.status);
        end else begin
          want = expected_specs.pop_front();
          check_field("status", want.status, res_if.status);
          check_field("fill_char", want.fill_char, res_if.fill_char);
          check_field("align_mode", want.align_mode, res_if.align_mode);
          check_field("sign_mode", want.sign_mode, res_if.sign_mode);
          check_field("no_negative_zero", want.no_negative_zero, res_if.no_negative_zero);
          check_field("alternate_form", want.alternate_form, res_if.alternate_form);
          check_field("field_width", want.field_width, res_if.field_width);
          check_field("grouping_mode", want.grouping_mode, res_if.grouping_mode);
          check_field("precision_value", want.precision_value, res_if.precision_value);
          check_field("type_char", want.type_char, res_if.type_char);
        end
      end
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[format_spec_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    spec_row_t        row;
    cp_t              chars [$];
    logic [CfgDataW-1:0] noise;
    int               random_end;

    in_if.valid      <= 1'b0;
    in_if.code_point <= CH_NUL;
    in_if.last_char  <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_DEFAULT_ALIGN;
    cfg_if.data      <= '0;
    reg_align = DefaultAlignRst;
    reg_type  = DefaultTypeRst;
    clear_spec();

    add_row("x", CH_NUL, 1'b1, plain_result('1, GRP_NONE, CH_X));
    add_row("2147483647", CH_NUL, 1'b1, plain_result(32'd2147483647, GRP_NONE, CH_NUL));
    add_row("2147483648", CH_NUL, 1'b1, only_status(ST_OVERFLOW));
    add_row(".2147483648");
    add_row(".", CH_NUL, 1'b1, only_status(ST_NO_PREC));
    add_row(".x", CH_NUL, 1'b1, only_status(ST_NO_PREC));
    add_row("5a5", CH_NUL, 1'b1, only_status(ST_INVALID));
    add_row("_,", CH_NUL, 1'b1, only_status(ST_CONFLICT));
    add_row(",_", CH_NUL, 1'b1, only_status(ST_CONFLICT));
    add_row(",d", CH_NUL, 1'b1, only_status(ST_SEP_TYPE));
    add_row("_x", CH_NUL, 1'b1, plain_result('1, GRP_FOUR, CH_X));
    add_row(",x");
    add_row("_b");
    add_row("_o");
    add_row("12_X");
    add_row(",@", CH_FEH);
    add_row("_@", CH_HEH);
    add_row(",.2@", CH_AIN);
    add_row(",@", CH_NUL);
    add_row(",%");
    add_row("0");
    add_row("08");
    add_row("@^+z#012,.3%", CP_MAX);
    add_row("@", CP_MAX);
    add_row("@=-z#0_.0b", 21'h0FFFFF);
    add_row(" 5");
    add_row("--");
    add_row("++x");
    add_row("x<0");
    add_row("<0");
    add_row("<");
    add_row("^<");

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      chars.delete();
      for (int k = 0; k < row.text.len(); k++) begin
        chars.push_back((row.text[k] == "@") ? row.subst : cp_t'(row.text[k]));
      end
      send_spec(chars);
      // The last character has just been transferred, so its result is still queued.
      if (row.known) expected_specs[expected_specs.size() - 1] = row.want;
    end

    random_end = chars_sent + RANDOM_CHARS;
    for (int r = 0; r < ROUNDS; r++) begin
      drain_results();
      if (r < 2 || $urandom_range(0, 1) == 1) begin
        noise      = CfgDataW'($urandom);
        noise[1:0] = round_align[r];
        write_reg(CFG_DEFAULT_ALIGN, noise);
      end
      if (r < 2 || $urandom_range(0, 1) == 1) write_reg(CFG_DEFAULT_TYPE, round_type[r]);
      while (chars_sent < random_end - (ROUNDS - 1 - r) * RANDOM_CHARS / ROUNDS) begin
        if (chars_sent > random_end - 300) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else if ($urandom_range(0, 39) == 0 || chars_sent < random_end - RANDOM_CHARS + 2) begin
          case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 5;
            2: gap_pct = 15;
            default: gap_pct = 40;
          endcase
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 3;
            2: stall_pct = 8;
            default: stall_pct = 20;
          endcase
        end
        compose_spec();
        send_spec(spec_chars);
      end
    end

    drain_results();
    if (mismatches == 0 && expected_specs.size() == 0) begin
      $display("[format_spec_parser] OK");
    end else begin
      $display("[format_spec_parser] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fsp_pkg.sv
src/fsp_if.sv
src/fsp_feed.sv
src/fsp_finish.sv
src/format_spec_parser.sv
dv/format_spec_parser_test.sv
